// File: rtl/acpd_pkg.sv
package acpd_pkg;

  localparam int PCT_W      = 7;
  localparam int MIN_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int WIN_N      = 10;
  localparam int FILL_W     = 4;
  localparam int PHASE_W    = 3;
  localparam int TRIM_SHIFT = 3;

  localparam logic [FILL_W-1:0] WIN_FULL = 4'd10;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_RST  = 7'd10;
  localparam logic [MIN_W-1:0] MIN_RST  = 12'd100;

  // floor(x / 100) == (x * RECIP_K) >> RECIP_SHIFT for x below 2**23
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_K = 26'd42949673;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_PERCENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL      = 1'd1;

endpackage

// File: rtl/acpd_in_if.sv
interface acpd_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/acpd_out_if.sv
interface acpd_out_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   card_present;
  logic [SAMPLE_BITS-1:0] baseline_out;
  logic [SAMPLE_BITS-1:0] margin_out;
  logic                   calibrated;

  modport source (output valid, output card_present, output baseline_out,
                  output margin_out, output calibrated, input ready);
  modport sink   (input valid, input card_present, input baseline_out,
                  input margin_out, input calibrated, output ready);
endinterface

// File: rtl/acpd_cfg.sv
module acpd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [acpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [acpd_pkg::PCT_W-1:0]         pct,
  output logic [acpd_pkg::MIN_W-1:0]         min_level
);

  logic [acpd_pkg::PCT_W-1:0] pct_r;
  logic [acpd_pkg::MIN_W-1:0] min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= acpd_pkg::PCT_RST;
      min_r <= acpd_pkg::MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        acpd_pkg::CFG_MARGIN_PERCENT: pct_r <= cfg_wdata[acpd_pkg::PCT_W-1:0];
        acpd_pkg::CFG_MIN_LEVEL:      min_r <= cfg_wdata[acpd_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp so the margin never exceeds the baseline
  assign pct       = (pct_r > acpd_pkg::PCT_FULL) ? acpd_pkg::PCT_FULL : pct_r;
  assign min_level = min_r;

endmodule

// File: rtl/acpd_track.sv
module acpd_track #(
  parameter int SAMPLE_BITS    = 12,
  parameter int RECHECK_PERIOD = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  acpd_in_if.sink                       in_if,
  input  logic [acpd_pkg::PCT_W-1:0]    cfg_pct,
  output logic                          trk_valid,
  input  logic                          trk_ready,
  output logic [SAMPLE_BITS-1:0]        trk_sample,
  output logic [SAMPLE_BITS-1:0]        trk_base,
  output logic [acpd_pkg::PCT_W-1:0]    trk_pct,
  output logic                          trk_cal
);

  localparam int PW   = SAMPLE_BITS + acpd_pkg::PCT_W;
  localparam int SUMW = SAMPLE_BITS + acpd_pkg::FILL_W;
  localparam int NP   = acpd_pkg::WIN_N / 2;

  logic                            a_valid_r;
  logic [SAMPLE_BITS-1:0]          a_sample_r;
  logic [SAMPLE_BITS-1:0]          win_r [acpd_pkg::WIN_N];
  logic [acpd_pkg::FILL_W-1:0]     fill_r;
  logic [SAMPLE_BITS-1:0]          base_r;
  logic [acpd_pkg::PCT_W-1:0]      pct_r;
  logic [acpd_pkg::PHASE_W-1:0]    phase_r;

  logic [acpd_pkg::PHASE_W-1:0]    phase_base;
  logic [acpd_pkg::PHASE_W-1:0]    phase_nxt;
  logic [SAMPLE_BITS-1:0]          diff;
  logic [PW-1:0]                   prod;
  logic [PW-1:0]                   lim;
  logic                            outside;
  logic                            full;
  logic                            take;
  logic                            fire;
  logic [SAMPLE_BITS-1:0]          sh   [acpd_pkg::WIN_N];
  logic [SUMW-1:0]                 psum [NP];
  logic [SAMPLE_BITS-1:0]          pmax [NP];
  logic [SAMPLE_BITS-1:0]          pmin [NP];
  logic [SUMW-1:0]                 tot;
  logic [SAMPLE_BITS-1:0]          hi;
  logic [SAMPLE_BITS-1:0]          lo;
  logic [SUMW-1:0]                 trimmed;
  logic [SAMPLE_BITS-1:0]          base_nxt;
  logic [acpd_pkg::FILL_W-1:0]     fill_nxt;

  assign in_if.ready = !a_valid_r || trk_ready;
  assign fire        = a_valid_r && trk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      a_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      a_sample_r <= in_if.sample;
    end
  end

  always_comb begin
    phase_base = (phase_r >= acpd_pkg::PHASE_W'(RECHECK_PERIOD)) ? '0 : phase_r;
    phase_nxt  = phase_base + 1'b1;
    diff       = (a_sample_r >= base_r) ? (a_sample_r - base_r) : (base_r - a_sample_r);
    prod       = PW'(base_r) * PW'(pct_r);
    lim        = PW'(diff) * PW'(acpd_pkg::PCT_FULL);
    outside    = prod < lim;
    full       = fill_r == acpd_pkg::WIN_FULL;
    take       = (fill_r == '0) ||
                 (((phase_nxt == acpd_pkg::PHASE_W'(RECHECK_PERIOD)) || !full) && !outside);
  end

  always_comb begin
    for (int k = 0; k < acpd_pkg::WIN_N - 1; k++) begin
      sh[k] = win_r[k+1];
    end
    sh[acpd_pkg::WIN_N-1] = a_sample_r;
    for (int j = 0; j < NP; j++) begin
      psum[j] = SUMW'(sh[2*j]) + SUMW'(sh[2*j+1]);
      pmax[j] = (sh[2*j] > sh[2*j+1]) ? sh[2*j] : sh[2*j+1];
      pmin[j] = (sh[2*j] < sh[2*j+1]) ? sh[2*j] : sh[2*j+1];
    end
    tot = (psum[0] + psum[1]) + (psum[2] + psum[3]) + psum[4];
    hi  = pmax[0];
    lo  = pmin[0];
    for (int j = 1; j < NP; j++) begin
      if (pmax[j] > hi) begin
        hi = pmax[j];
      end
      if (pmin[j] < lo) begin
        lo = pmin[j];
      end
    end
    trimmed  = (tot - SUMW'(hi) - SUMW'(lo)) >> acpd_pkg::TRIM_SHIFT;
    base_nxt = full ? trimmed[SAMPLE_BITS-1:0] : a_sample_r;
    fill_nxt = (take && !full) ? (fill_r + 1'b1) : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      base_r  <= '0;
      pct_r   <= '0;
      phase_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      if (take) begin
        base_r <= base_nxt;
        pct_r  <= cfg_pct;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && take) begin
      for (int k = 0; k < acpd_pkg::WIN_N; k++) begin
        if (full) begin
          win_r[k] <= sh[k];
        end else if (fill_r == acpd_pkg::FILL_W'(k)) begin
          win_r[k] <= a_sample_r;
        end
      end
    end
  end

  assign trk_valid  = a_valid_r;
  assign trk_sample = a_sample_r;
  assign trk_base   = take ? base_nxt : base_r;
  assign trk_pct    = take ? cfg_pct : pct_r;
  assign trk_cal    = fill_nxt == acpd_pkg::WIN_FULL;

endmodule

// File: rtl/acpd_detect.sv
module acpd_detect #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          trk_valid,
  output logic                          trk_ready,
  input  logic [SAMPLE_BITS-1:0]        trk_sample,
  input  logic [SAMPLE_BITS-1:0]        trk_base,
  input  logic [acpd_pkg::PCT_W-1:0]    trk_pct,
  input  logic                          trk_cal,
  input  logic [acpd_pkg::MIN_W-1:0]    min_level,
  acpd_out_if.source                    out_if
);

  localparam int PW   = SAMPLE_BITS + acpd_pkg::PCT_W;
  localparam int MW   = PW + acpd_pkg::RECIP_W;
  localparam int CMPW = (SAMPLE_BITS > acpd_pkg::MIN_W) ? SAMPLE_BITS : acpd_pkg::MIN_W;

  logic                         b_valid_r;
  logic [SAMPLE_BITS-1:0]       b_sample_r;
  logic [SAMPLE_BITS-1:0]       b_base_r;
  logic [acpd_pkg::PCT_W-1:0]   b_pct_r;
  logic                         b_cal_r;

  logic                         c_valid_r;
  logic [PW-1:0]                c_prod_r;
  logic [SAMPLE_BITS-1:0]       c_base_r;
  logic                         c_present_r;
  logic                         c_cal_r;

  logic                         o_valid_r;
  logic                         o_present_r;
  logic [SAMPLE_BITS-1:0]       o_base_r;
  logic [SAMPLE_BITS-1:0]       o_margin_r;
  logic                         o_cal_r;

  logic                         c_ready;
  logic                         o_ready;
  logic [SAMPLE_BITS-1:0]       b_diff;
  logic [PW-1:0]                b_prod;
  logic [PW-1:0]                b_lim;
  logic                         b_present;
  logic [MW-1:0]                c_scaled;

  assign o_ready   = !o_valid_r || out_if.ready;
  assign c_ready   = !c_valid_r || o_ready;
  assign trk_ready = !b_valid_r || c_ready;

  always_comb begin
    b_diff    = (b_sample_r >= b_base_r) ? (b_sample_r - b_base_r)
                                         : (b_base_r - b_sample_r);
    b_prod    = PW'(b_base_r) * PW'(b_pct_r);
    b_lim     = PW'(b_diff) * PW'(acpd_pkg::PCT_FULL);
    b_present = (CMPW'(b_sample_r) >= CMPW'(min_level)) && (b_prod < b_lim);
    c_scaled  = MW'(c_prod_r) * MW'(acpd_pkg::RECIP_K);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (trk_ready) begin
        b_valid_r <= trk_valid;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
      if (o_ready) begin
        o_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (trk_valid && trk_ready) begin
      b_sample_r <= trk_sample;
      b_base_r   <= trk_base;
      b_pct_r    <= trk_pct;
      b_cal_r    <= trk_cal;
    end
    if (b_valid_r && c_ready) begin
      c_prod_r    <= b_prod;
      c_base_r    <= b_base_r;
      c_present_r <= b_present;
      c_cal_r     <= b_cal_r;
    end
    if (c_valid_r && o_ready) begin
      o_present_r <= c_present_r;
      o_base_r    <= c_base_r;
      o_margin_r  <= c_scaled[acpd_pkg::RECIP_SHIFT +: SAMPLE_BITS];
      o_cal_r     <= c_cal_r;
    end
  end

  assign out_if.valid        = o_valid_r;
  assign out_if.card_present = o_present_r;
  assign out_if.baseline_out = o_base_r;
  assign out_if.margin_out   = o_margin_r;
  assign out_if.calibrated   = o_cal_r;

endmodule

// File: rtl/adc_card_presence_detector_top.sv
// Channel   Dir  Beat / write
// in_if     in   sample
// out_if    out  card_present, baseline_out, margin_out, calibrated
// cfg_*     in   cfg_we, cfg_idx (0 margin percent, 1 min level), cfg_wdata
//
// One beat per cycle in each direction while out_if.ready stays high; a result is
// valid after input register, band test, margin multiply and output register.
// The baseline and window update in the cycle a sample leaves the input register.
// rst_n is synchronous: it empties every stage and clears fill count, baseline,
// phase and margin; the window holds no reset and is read only once full.
// Each stage holds its beat while the next one is full and stalled.
module adc_card_presence_detector_top #(
  parameter int SAMPLE_BITS    = 12,
  parameter int RECHECK_PERIOD = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  acpd_in_if.sink                          in_if,
  acpd_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [acpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [acpd_pkg::PCT_W-1:0]  pct;
  logic [acpd_pkg::MIN_W-1:0]  min_level;
  logic                        trk_valid;
  logic                        trk_ready;
  logic [SAMPLE_BITS-1:0]      trk_sample;
  logic [SAMPLE_BITS-1:0]      trk_base;
  logic [acpd_pkg::PCT_W-1:0]  trk_pct;
  logic                        trk_cal;

  acpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pct       (pct),
    .min_level (min_level)
  );

  acpd_track #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .RECHECK_PERIOD (RECHECK_PERIOD)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_pct    (pct),
    .trk_valid  (trk_valid),
    .trk_ready  (trk_ready),
    .trk_sample (trk_sample),
    .trk_base   (trk_base),
    .trk_pct    (trk_pct),
    .trk_cal    (trk_cal)
  );

  acpd_detect #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_detect (
    .clk        (clk),
    .rst_n      (rst_n),
    .trk_valid  (trk_valid),
    .trk_ready  (trk_ready),
    .trk_sample (trk_sample),
    .trk_base   (trk_base),
    .trk_pct    (trk_pct),
    .trk_cal    (trk_cal),
    .min_level  (min_level),
    .out_if     (out_if)
  );

endmodule

// File: tb/sv/acpd_band_checker.sv
module acpd_band_checker #(
  parameter int RECHECK_PERIOD = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  acpd_in_if                               in_ch,
  acpd_out_if                              out_ch,
  input  logic                             cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [acpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             busy,
  output int                               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        card_present;
    logic [11:0] baseline;
    logic [11:0] margin;
    logic        calibrated;
  } detect_t;

  logic [acpd_pkg::PCT_W-1:0]   band_pct;
  logic [acpd_pkg::MIN_W-1:0]   min_lvl;
  logic [11:0]                  win_buf [acpd_pkg::WIN_N];
  logic [acpd_pkg::FILL_W-1:0]  fill;
  logic [11:0]                  base_lvl;
  logic [11:0]                  band_half;
  logic [acpd_pkg::PHASE_W-1:0] phase_cnt;

  detect_t detect_q[$];
  int      outstanding = 0;

  assign busy = (outstanding != 0);

  function automatic logic out_of_band(input logic [11:0] s);
    return (int'(s) + int'(band_half) < int'(base_lvl)) ||
           (int'(s) > int'(base_lvl) + int'(band_half));
  endfunction

  task automatic absorb(input logic [11:0] s);
    int total;
    int hi;
    int lo;
    int pct_eff;
    if (fill < acpd_pkg::WIN_N) begin
      win_buf[fill] = s;
      fill = fill + 1'b1;
      base_lvl = s;
    end else begin
      for (int k = 0; k < acpd_pkg::WIN_N - 1; k++) win_buf[k] = win_buf[k+1];
      win_buf[acpd_pkg::WIN_N-1] = s;
      total = 0;
      hi = win_buf[0];
      lo = win_buf[0];
      for (int k = 0; k < acpd_pkg::WIN_N; k++) begin
        total += win_buf[k];
        if (win_buf[k] > hi) hi = win_buf[k];
        if (win_buf[k] < lo) lo = win_buf[k];
      end
      base_lvl = 12'((total - hi - lo) >> acpd_pkg::TRIM_SHIFT);
    end
    pct_eff = (band_pct > acpd_pkg::PCT_FULL) ? int'(acpd_pkg::PCT_FULL) : int'(band_pct);
    band_half = 12'((int'(base_lvl) * pct_eff) / int'(acpd_pkg::PCT_FULL));
  endtask

  task automatic step_detector(input logic [11:0] s, output detect_t r);
    logic took;
    took = 1'b0;
    if (phase_cnt >= RECHECK_PERIOD) phase_cnt = '0;
    phase_cnt = phase_cnt + 1'b1;
    if ((phase_cnt == RECHECK_PERIOD || fill < acpd_pkg::WIN_N) && !out_of_band(s)) begin
      absorb(s);
      took = 1'b1;
    end
    if (!took && fill == 0) absorb(s);
    r.card_present = (s >= min_lvl) && out_of_band(s);
    r.baseline     = base_lvl;
    r.margin       = band_half;
    r.calibrated   = (fill >= acpd_pkg::WIN_FULL);
  endtask

  always @(posedge clk) begin
    detect_t want;
    detect_t got;
    if (!rst_n) begin
      band_pct  = acpd_pkg::PCT_RST;
      min_lvl   = acpd_pkg::MIN_RST;
      fill      = '0;
      base_lvl  = '0;
      band_half = '0;
      phase_cnt = '0;
      detect_q.delete();
      outstanding = 0;
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          acpd_pkg::CFG_MARGIN_PERCENT: band_pct = cfg_wdata[acpd_pkg::PCT_W-1:0];
          acpd_pkg::CFG_MIN_LEVEL:      min_lvl  = cfg_wdata[acpd_pkg::MIN_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.card_present, out_ch.baseline_out, out_ch.margin_out,
                out_ch.calibrated};
        if (detect_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          fail_count++;
        end else begin
          want = detect_q.pop_front();
          outstanding--;
          if (got.card_present !== want.card_present) begin
            $display("%0t: card_present expected %0d actual %0d", $time,
                     want.card_present, got.card_present);
            fail_count++;
          end
          if (got.baseline !== want.baseline) begin
            $display("%0t: baseline_out expected %0d actual %0d", $time,
                     want.baseline, got.baseline);
            fail_count++;
          end
          if (got.margin !== want.margin) begin
            $display("%0t: margin_out expected %0d actual %0d", $time,
                     want.margin, got.margin);
            fail_count++;
          end
          if (got.calibrated !== want.calibrated) begin
            $display("%0t: calibrated expected %0d actual %0d", $time,
                     want.calibrated, got.calibrated);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_detector(in_ch.sample, want);
        detect_q.push_back(want);
        outstanding++;
      end
    end
  end

endmodule

// File: tb/sv/tb_adc_card_presence_detector_top.sv
module tb_adc_card_presence_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [acpd_pkg::CFG_IDX_W-1:0]  cfg_idx = acpd_pkg::CFG_MARGIN_PERCENT;
  logic [acpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            busy;
  int                              fail_count;
  logic                            idle_en = 1'b1;
  int                              cur_pct = acpd_pkg::PCT_RST;
  int                              level = 2000;
  int                              quiet_cycles = 0;

  acpd_in_if  #(.SAMPLE_BITS(12)) in_ch ();
  acpd_out_if #(.SAMPLE_BITS(12)) out_ch ();

  adc_card_presence_detector_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  acpd_band_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .fail_count(fail_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_adc_card_presence_detector_top failed");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic send_sample(input logic [11:0] s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= 12'($urandom_range(0, 4095));
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic set_band(input int pct, input int min_lvl);
    in_ch.valid <= 1'b0;
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= acpd_pkg::CFG_MARGIN_PERCENT;
    cfg_wdata <= acpd_pkg::CFG_DATA_W'(pct);
    @(negedge clk);
    cfg_idx   <= acpd_pkg::CFG_MIN_LEVEL;
    cfg_wdata <= acpd_pkg::CFG_DATA_W'(min_lvl);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_pct = pct;
  endtask

  task automatic run_samples(input int n, input int target, input int stride);
    int spread;
    int pick;
    int s;
    repeat (n) begin
      if (level < target) level += $urandom_range(0, stride);
      else if (level > target) level -= $urandom_range(0, stride);
      level = (level < 0) ? 0 : (level > 4095) ? 4095 : level;
      spread = (level * ((cur_pct > 100) ? 100 : cur_pct)) / 200;
      pick = $urandom_range(0, 99);
      if (pick < 65) s = level + $urandom_range(0, 2 * spread) - spread;
      else if (pick < 80) s = level;
      else if (pick < 92) s = $urandom_range(0, 4095);
      else s = $urandom_range(0, 1) ? 4095 : 0;
      s = (s < 0) ? 0 : (s > 4095) ? 4095 : s;
      send_sample(12'(s));
    end
  endtask

  initial begin
    int opening [] = '{2000, 2200, 1980, 2179, 1781, 0, 2000, 2010, 1990, 2005,
                       1995, 2000, 2000, 4095, 0, 2000, 2000, 2000, 2000, 2000};
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_band(10, 100);
    foreach (opening[i]) send_sample(12'(opening[i]));
    level = 2000;

    set_band(25, 0);
    run_samples(120, 2000, 8);
    set_band(0, 4095);
    run_samples(80, level, 0);
    set_band(100, 2048);
    run_samples(100, 4095, 60);
    set_band(127, 0);
    run_samples(80, 4095, 0);
    set_band($urandom_range(0, 127), $urandom_range(0, 4095));
    run_samples(100, $urandom_range(0, 4095), 20);

    idle_en = 1'b0;
    set_band(100, 0);
    run_samples(100, 0, 60);

    in_ch.valid <= 1'b0;
    while (busy) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_adc_card_presence_detector_top passed");
    end else begin
      $display("tb_adc_card_presence_detector_top failed");
    end
    $finish;
  end

endmodule

// File: adc_card_presence_detector_top.f
rtl/acpd_pkg.sv
rtl/acpd_in_if.sv
rtl/acpd_out_if.sv
rtl/acpd_cfg.sv
rtl/acpd_track.sv
rtl/acpd_detect.sv
rtl/adc_card_presence_detector_top.sv
tb/sv/acpd_band_checker.sv
tb/sv/tb_adc_card_presence_detector_top.sv
